// ===== rtl/clt_pkg.sv =====
// Shared constants and command codes for the cluster label table.
package clt_pkg;

  localparam int CMD_W     = 3;
  localparam int VERTEX_W  = 10;
  localparam int LABEL_W   = 8;
  localparam int TALLY_W   = 11;
  localparam int NV_W      = 11;

  // labels are stored at full port width, so folding is the identity
  localparam int LABEL_RANGE = 1 << LABEL_W;

  localparam int DEF_MAX_VERTICES = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_ASSIGN    = 3'd0,
    CMD_READ      = 3'd1,
    CMD_COUNT     = 3'd2,
    CMD_CLUSTERS  = 3'd3,
    CMD_NORMALIZE = 3'd4
  } cmd_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

endpackage

// ===== rtl/clt_if.sv =====
// Valid/ready channel interfaces: command, result and configuration.
interface clt_in_if;
  logic                          valid;
  logic                          ready;
  logic [clt_pkg::CMD_W-1:0]     cmd;
  logic [clt_pkg::VERTEX_W-1:0]  vertex;
  logic [clt_pkg::LABEL_W-1:0]   label_in;

  modport source(output valid, output cmd, output vertex, output label_in, input ready);
  modport sink(input valid, input cmd, input vertex, input label_in, output ready);
endinterface

interface clt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [clt_pkg::LABEL_W-1:0]   label_out;
  logic [clt_pkg::TALLY_W-1:0]   tally;

  modport source(output valid, output status, output label_out, output tally, input ready);
  modport sink(input valid, input status, input label_out, input tally, output ready);
endinterface

interface clt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [clt_pkg::NV_W-1:0]      num_vertices;

  modport source(output valid, output num_vertices, input ready);
  modport sink(input valid, input num_vertices, output ready);
endinterface

// ===== rtl/cluster_label_table.sv =====
// Cluster label table: per-vertex label memory with count and first-seen relabeling.
// n = min(num_vertices, MAX_VERTICES). Commands run one at a time, ending in S_EMIT;
// an in-range read passes S_RDATA, count and cluster count scan n entries (paced by the
// label memory's read port); normalize, if not done, visits each in S_NLK, S_NWR if seen.
// After rst_n a clearing pass writes zero to all MAX_VERTICES entries, one per cycle;
// in ready is low then; configuration writes are taken only while idle or clearing.
module cluster_label_table #(
  parameter int MAX_VERTICES = clt_pkg::DEF_MAX_VERTICES
) (
  input  logic      clk,
  input  logic      rst_n,
  clt_in_if.sink    in_chan,
  clt_out_if.source out_chan,
  clt_cfg_if.sink   cfg_chan
);

  import clt_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = ($clog2(MAX_VERTICES + 1) > NV_W) ? $clog2(MAX_VERTICES + 1) : NV_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RDATA, S_SCAN_CNT, S_SCAN_CL, S_NLK, S_NWR, S_EMIT
  } state_t;

  state_t               state_r;
  logic [VW-1:0]        idx_r;
  logic [CW-1:0]        nv_r;
  logic [CW-1:0]        cnt_r;
  logic [LABEL_W-1:0]   lab_r;
  logic [LABEL_W:0]     next_r;
  logic [LABEL_RANGE-1:0] seen_r;
  logic                 norm_r;
  logic                 res_status_r;
  logic [LABEL_W-1:0]   res_label_r;
  logic [TALLY_W-1:0]   res_tally_r;
  logic                 out_valid_r;
  logic                 out_status_r;
  logic [LABEL_W-1:0]   out_label_r;
  logic [TALLY_W-1:0]   out_tally_r;

  logic [CW-1:0]        n_eff;
  logic [CW-1:0]        idx_inc;
  logic                 last;
  logic                 range_err;
  logic [VW-1:0]        vtx_addr;
  logic                 in_acc;
  logic                 cfg_acc;
  logic                 hit;
  logic [CW-1:0]        cnt_inc;

  logic                 v_we;
  logic [VW-1:0]        v_waddr;
  logic [LABEL_W-1:0]   v_wdata;
  logic [VW-1:0]        v_raddr;
  logic [LABEL_W-1:0]   v_rdata;
  logic                 m_we;
  logic [LABEL_W-1:0]   m_waddr;
  logic [LABEL_W-1:0]   m_wdata;
  logic [LABEL_W-1:0]   m_raddr;
  logic [LABEL_W-1:0]   m_rdata;

  clt_ram #(.DEPTH(MAX_VERTICES), .WIDTH(LABEL_W)) u_labels (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  clt_ram #(.DEPTH(LABEL_RANGE), .WIDTH(LABEL_W)) u_rename (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  // a pending configuration write goes first and holds off the next command
  assign in_chan.ready      = (state_r == S_IDLE) && !cfg_chan.valid;
  assign cfg_chan.ready     = (state_r == S_IDLE) || (state_r == S_CLEAR);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.label_out = out_label_r;
  assign out_chan.tally     = out_tally_r;

  assign in_acc    = in_chan.valid && (state_r == S_IDLE) && !cfg_chan.valid;
  assign cfg_acc   = cfg_chan.valid && ((state_r == S_IDLE) || (state_r == S_CLEAR));
  assign n_eff     = (nv_r < CW'(MAX_VERTICES)) ? nv_r : CW'(MAX_VERTICES);
  assign range_err = (CW'(in_chan.vertex) >= n_eff);
  assign vtx_addr  = VW'(in_chan.vertex);
  assign idx_inc   = CW'(idx_r) + CW'(1);
  assign last      = (idx_inc >= n_eff);
  assign hit       = (state_r == S_SCAN_CNT) ? (v_rdata == lab_r) : !seen_r[v_rdata];
  assign cnt_inc   = cnt_r + CW'(hit);

  always_comb begin
    v_we    = 1'b0;
    v_waddr = idx_r;
    v_wdata = '0;
    v_raddr = VW'(idx_inc);
    m_we    = 1'b0;
    m_waddr = v_rdata;
    m_wdata = next_r[LABEL_W-1:0];
    m_raddr = v_rdata;
    unique case (state_r)
      S_CLEAR: begin
        v_we = 1'b1;
      end
      S_IDLE: begin
        v_raddr = (in_chan.cmd == CMD_READ) ? vtx_addr : '0;
        if (in_acc && in_chan.cmd == CMD_ASSIGN && !range_err) begin
          v_we    = 1'b1;
          v_waddr = vtx_addr;
          v_wdata = in_chan.label_in;
        end
      end
      S_NLK: begin
        // first sighting: allocate the next dense label
        if (!seen_r[v_rdata]) begin
          m_we    = 1'b1;
          v_we    = 1'b1;
          v_wdata = next_r[LABEL_W-1:0];
        end
      end
      S_NWR: begin
        v_we    = 1'b1;
        v_wdata = m_rdata;
      end
      S_RDATA, S_SCAN_CNT, S_SCAN_CL, S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      nv_r        <= CW'(MAX_VERTICES);
      norm_r      <= 1'b0;
      seen_r      <= '0;
      next_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_chan.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (idx_r == VW'(MAX_VERTICES - 1)) begin
            idx_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            idx_r <= VW'(idx_inc);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            res_status_r <= STATUS_OK;
            res_label_r  <= '0;
            res_tally_r  <= '0;
            cnt_r        <= '0;
            idx_r        <= '0;
            lab_r        <= in_chan.label_in;
            unique case (cmd_t'(in_chan.cmd))
              CMD_ASSIGN: begin
                if (range_err) begin
                  res_status_r <= STATUS_RANGE;
                end else begin
                  norm_r <= 1'b0;
                end
                state_r <= S_EMIT;
              end
              CMD_READ: begin
                if (range_err) begin
                  res_status_r <= STATUS_RANGE;
                  state_r      <= S_EMIT;
                end else begin
                  state_r <= S_RDATA;
                end
              end
              CMD_COUNT: begin
                state_r <= (n_eff == '0) ? S_EMIT : S_SCAN_CNT;
              end
              CMD_CLUSTERS: begin
                seen_r  <= '0;
                state_r <= (n_eff == '0) ? S_EMIT : S_SCAN_CL;
              end
              CMD_NORMALIZE: begin
                if (norm_r) begin
                  state_r <= S_EMIT;
                end else begin
                  seen_r <= '0;
                  next_r <= '0;
                  if (n_eff == '0) begin
                    norm_r  <= 1'b1;
                    state_r <= S_EMIT;
                  end else begin
                    state_r <= S_NLK;
                  end
                end
              end
              default: begin
                state_r <= S_EMIT;
              end
            endcase
          end
        end
        S_RDATA: begin
          res_label_r <= v_rdata;
          state_r     <= S_EMIT;
        end
        S_SCAN_CNT, S_SCAN_CL: begin
          if (state_r == S_SCAN_CL) begin
            seen_r[v_rdata] <= 1'b1;
          end
          cnt_r <= cnt_inc;
          if (last) begin
            res_tally_r <= cnt_inc[TALLY_W-1:0];
            state_r     <= S_EMIT;
          end else begin
            idx_r <= VW'(idx_inc);
          end
        end
        S_NLK: begin
          if (seen_r[v_rdata]) begin
            state_r <= S_NWR;
          end else begin
            seen_r[v_rdata] <= 1'b1;
            next_r          <= next_r + 1'b1;
            if (last) begin
              norm_r  <= 1'b1;
              state_r <= S_EMIT;
            end else begin
              idx_r <= VW'(idx_inc);
            end
          end
        end
        S_NWR: begin
          if (last) begin
            norm_r  <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            idx_r   <= VW'(idx_inc);
            state_r <= S_NLK;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_label_r  <= res_label_r;
            out_tally_r  <= res_tally_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cfg_acc) begin
        nv_r   <= CW'(cfg_chan.num_vertices);
        norm_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/clt_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module clt_ram #(
  parameter int DEPTH = clt_pkg::DEF_MAX_VERTICES,
  parameter int WIDTH = clt_pkg::LABEL_W,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/clt_checker.sv =====
// Port-level checks for the cluster label table, bound to the top level.
module clt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_status,
  input logic [clt_pkg::LABEL_W-1:0]  out_label_out,
  input logic [clt_pkg::TALLY_W-1:0]  out_tally
);

  import clt_pkg::*;

  // clearing pass follows every reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in ready high right after reset");

  // one command at a time: in ready is low in the cycle after a word is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken on consecutive cycles");

  a_err_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_RANGE) |-> (out_label_out == '0 && out_tally == '0))
    else $error("range error word carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_label_out) && $stable(out_tally)))
    else $error("stalled result word changed");

endmodule

bind cluster_label_table clt_checker u_clt_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_chan.valid),
  .in_ready(in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_status(out_chan.status),
  .out_label_out(out_chan.label_out),
  .out_tally(out_chan.tally)
);

// ===== sim/tb_top.sv =====
// Testbench for cluster_label_table: queued command driver, result monitor, inline label table model.
`timescale 1ns / 100ps

module tb_top;
  import clt_pkg::*;

  localparam int TBL_DEPTH        = DEF_MAX_VERTICES;
  localparam int IDLE_LIMIT       = 20000;
  localparam int DRAIN_CYCLES     = 16;
  localparam int CMD_FIRST_UNUSED = CMD_NORMALIZE + 1;
  localparam int CMD_LAST_CODE    = (1 << CMD_W) - 1;
  localparam int POOL_SIZE        = 4;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [VERTEX_W-1:0] vertex;
    logic [LABEL_W-1:0]  label;
  } table_cmd_t;

  typedef struct packed {
    logic               status;
    logic [LABEL_W-1:0] label_out;
    logic [TALLY_W-1:0] tally;
  } table_result_t;

  logic clk;
  logic rst_n;

  clt_in_if  in_chan();
  clt_out_if out_chan();
  clt_cfg_if cfg_chan();

  cluster_label_table #(.MAX_VERTICES(TBL_DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  table_cmd_t    cmd_backlog [$];
  table_result_t expected_results [$];

  // shadow copy of the label table and its control state
  logic [LABEL_W-1:0] label_mem [TBL_DEPTH] = '{default: '0};
  logic [NV_W-1:0]    nv_reg     = NV_W'(TBL_DEPTH);
  bit                 normalized = 1'b0;

  logic        in_took     = 1'b0;
  logic        cfg_took    = 1'b0;
  int unsigned words_in    = 0;
  int unsigned words_queued = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count  = 0;
  bit          calm        = 1'b0;

  int burst_left = 1;
  int gap_left   = 0;
  int rx_run     = 0;
  bit rx_level   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic table_result_t apply_command(table_cmd_t c);
    table_result_t      r;
    int unsigned        n;
    int unsigned        next_label;
    logic [LABEL_W-1:0] l;
    bit                 seen [LABEL_RANGE];
    logic [LABEL_W-1:0] remap [LABEL_RANGE];
    r = '0;
    n = (nv_reg < TBL_DEPTH) ? nv_reg : TBL_DEPTH;
    case (c.cmd)
      CMD_ASSIGN: begin
        if (c.vertex >= n) begin
          r.status = STATUS_RANGE;
        end else begin
          label_mem[c.vertex] = c.label;
          normalized = 1'b0;
        end
      end
      CMD_READ: begin
        if (c.vertex >= n) r.status = STATUS_RANGE;
        else r.label_out = label_mem[c.vertex];
      end
      CMD_COUNT: begin
        for (int i = 0; i < n; i++)
          if (label_mem[i] == c.label) r.tally = r.tally + 1'b1;
      end
      CMD_CLUSTERS: begin
        for (int i = 0; i < n; i++) begin
          if (!seen[label_mem[i]]) begin
            seen[label_mem[i]] = 1'b1;
            r.tally = r.tally + 1'b1;
          end
        end
      end
      CMD_NORMALIZE: begin
        if (!normalized) begin
          // rename in order of first appearance, vertex 0 upward
          next_label = 0;
          for (int i = 0; i < n; i++) begin
            l = label_mem[i];
            if (!seen[l]) begin
              seen[l] = 1'b1;
              remap[l] = LABEL_W'(next_label);
              next_label++;
            end
            label_mem[i] = remap[l];
          end
          normalized = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void queue_word(logic [CMD_W-1:0] c, logic [VERTEX_W-1:0] v,
                                     logic [LABEL_W-1:0] l);
    table_cmd_t w;
    w.cmd = c;
    w.vertex = v;
    w.label = l;
    cmd_backlog = {cmd_backlog, w};
    words_queued++;
  endfunction

  // monitor: check results, predict on accepted commands, track config writes
  always @(posedge clk) begin
    table_result_t want;
    table_result_t pred;
    table_cmd_t    got;
    bit            moved;
    moved = 1'b0;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      moved = 1'b1;
      if (expected_results.size() == 0) begin
        $error("result word arrived with no expected result pending");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_chan.status);
          fail_count++;
        end
        if (out_chan.label_out !== want.label_out) begin
          $error("label_out: expected %0d, actual %0d", want.label_out, out_chan.label_out);
          fail_count++;
        end
        if (out_chan.tally !== want.tally) begin
          $error("tally: expected %0d, actual %0d", want.tally, out_chan.tally);
          fail_count++;
        end
      end
    end
    in_took <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      moved = 1'b1;
      got.cmd = in_chan.cmd;
      got.vertex = in_chan.vertex;
      got.label = in_chan.label_in;
      pred = apply_command(got);
      expected_results = {expected_results, pred};
      words_in++;
    end
    cfg_took <= rst_n && cfg_chan.valid && cfg_chan.ready;
    if (rst_n && cfg_chan.valid && cfg_chan.ready) begin
      moved = 1'b1;
      nv_reg = cfg_chan.num_vertices;
      normalized = 1'b0;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  // command driver: bursts of words with random gaps
  always @(negedge clk) begin
    table_cmd_t nxt;
    if (rst_n && !(in_chan.valid && !in_took)) begin
      if (gap_left > 0 && !calm) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        nxt = cmd_backlog.pop_front();
        in_chan.cmd      <= nxt.cmd;
        in_chan.vertex   <= nxt.vertex;
        in_chan.label_in <= nxt.label;
        in_chan.valid    <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result receiver: alternating ready runs and stall runs
  always @(negedge clk) begin
    if (calm) begin
      out_chan.ready <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_level = !rx_level;
        rx_run = rx_level ? $urandom_range(1, 20) : $urandom_range(1, 6);
      end
      rx_run--;
      out_chan.ready <= rx_level;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("cluster_label_table verification failed");
    $finish;
  end

  task automatic write_vertex_count(input logic [NV_W-1:0] value);
    @(negedge clk);
    cfg_chan.num_vertices <= value;
    cfg_chan.valid <= 1'b1;
    do @(negedge clk); while (!cfg_took);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic drain();
    while (words_in != words_queued || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [NV_W-1:0] nv, input int count, input bit quiet);
    int unsigned        eff;
    int unsigned        pick;
    int unsigned        scan_pct;
    logic [CMD_W-1:0]   c;
    logic [VERTEX_W-1:0] v;
    logic [LABEL_W-1:0] l;
    logic [LABEL_W-1:0] pool [POOL_SIZE];
    eff = (nv < TBL_DEPTH) ? nv : TBL_DEPTH;
    write_vertex_count(nv);
    calm = quiet;
    // small labels stay common after a normalize pass
    foreach (pool[k]) pool[k] = (k < 2) ? LABEL_W'($urandom_range(0, 3)) : LABEL_W'($urandom);
    // full-table scans are slow, keep them rare on big tables
    scan_pct = (eff > 256) ? 6 : 40;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        c = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
      end else if (pick < 5 + scan_pct) begin
        case ($urandom_range(0, 3))
          0, 1:    c = CMD_COUNT;
          2:       c = CMD_CLUSTERS;
          default: c = CMD_NORMALIZE;
        endcase
      end else begin
        c = ($urandom_range(0, 99) < 65) ? CMD_ASSIGN : CMD_READ;
      end
      if (eff > 0 && $urandom_range(0, 9) < 8) v = VERTEX_W'($urandom_range(0, eff - 1));
      else v = VERTEX_W'($urandom);
      l = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                      : LABEL_W'($urandom);
      queue_word(c, v, l);
    end
    drain();
  endtask

  initial begin
    int nv_plan [14];
    nv_plan = '{16, 1, 1024, 5, 2047, 64, 2, 200, 0, 33, 1024, 3, 128, 9};
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.cmd = '0;
    in_chan.vertex = '0;
    in_chan.label_in = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.num_vertices = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full table straight out of reset
    queue_word(CMD_CLUSTERS, '0, '0);
    queue_word(CMD_NORMALIZE, '0, '0);
    queue_word(CMD_NORMALIZE, '0, '0);   // already normalized, skipped
    queue_word(CMD_ASSIGN, 10'd0, 8'd255);
    queue_word(CMD_ASSIGN, 10'd1023, 8'd255);
    queue_word(CMD_READ, 10'd1023, '0);
    queue_word(CMD_READ, 10'd0, '0);
    queue_word(CMD_COUNT, '0, 8'd255);
    queue_word(CMD_COUNT, '0, 8'd0);
    queue_word(CMD_CLUSTERS, '0, '0);
    queue_word(CMD_ASSIGN, 10'd5, 8'd170);
    queue_word(CMD_ASSIGN, 10'd6, 8'd85);
    queue_word(CMD_NORMALIZE, '0, '0);
    queue_word(CMD_READ, 10'd5, 8'd255);
    queue_word(CMD_READ, 10'd1023, '0);
    queue_word(CMD_NORMALIZE, '0, '0);
    queue_word(CMD_W'(CMD_FIRST_UNUSED), 10'd1023, 8'd255);
    queue_word(CMD_W'(CMD_LAST_CODE), '0, '0);
    drain();

    // small table: out-of-range vertices, unused tail left untouched
    write_vertex_count(NV_W'(8));
    queue_word(CMD_ASSIGN, 10'd8, 8'd7);
    queue_word(CMD_READ, 10'd1023, '0);
    queue_word(CMD_ASSIGN, 10'd7, 8'd255);
    queue_word(CMD_COUNT, '0, 8'd1);
    queue_word(CMD_NORMALIZE, '0, '0);
    queue_word(CMD_READ, 10'd7, '0);
    drain();

    // no vertices in use
    write_vertex_count('0);
    queue_word(CMD_COUNT, '0, 8'd0);
    queue_word(CMD_CLUSTERS, '0, '0);
    queue_word(CMD_NORMALIZE, '0, '0);
    queue_word(CMD_READ, 10'd0, '0);
    drain();

    foreach (nv_plan[k]) run_phase(NV_W'(nv_plan[k]), 68, (k % 4) == 1);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("cluster_label_table verification clean");
    end else begin
      $display("cluster_label_table verification failed");
    end
    $finish;
  end

endmodule
